>>> rtl/rt_pkg.sv
// ----------------------------------------------------------------------------
// rt_pkg
// Shared constants and types for the rank transform block.
// ----------------------------------------------------------------------------
package rt_pkg;

    localparam int DATA_W        = 32;
    localparam int DEF_MAX_COUNT = 64;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_DRAIN,
        ST_EMIT
    } t_state;

endpackage : rt_pkg

>>> rtl/rank_transform_top.sv
// ----------------------------------------------------------------------------
// rank_transform_top
// Rank transform of a signed list: each element is replaced by the number of
// list elements strictly smaller than it, emitted in input order.
//
// Channel   Direction  Handshake                 Payload
// input     in         i_start, o_busy           i_value, i_last
// result    out        o_valid                   o_result, o_last_res, o_truncated
//
// Loading takes one item per cycle; each item walks the cell chain one cell
// per cycle, counting smaller values as it passes and settling in the first
// free cell. After the item marked last, busy holds until all items have
// settled, then one result per cycle comes out of the head of the chain as the
// cells shift toward it; a one-element list returns the element itself.
// Synchronous reset empties the list. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module rank_transform_top
    import rt_pkg::*;
#(
    parameter int MAX_COUNT = DEF_MAX_COUNT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     i_last,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_result,
    output logic                     o_last_res,
    output logic                     o_truncated
);

    localparam int RANK_W = $clog2(MAX_COUNT);
    localparam int CNT_W  = $clog2(MAX_COUNT + 1);
    localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_COUNT);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_left, n_left;
    logic             r_ovf, n_ovf;

    logic accept;
    logic store;
    logic shift;
    logic any_trav;

    logic [MAX_COUNT:0]        trav_vld;
    logic signed [DATA_W-1:0]  trav_value [0:MAX_COUNT];
    logic [RANK_W-1:0]         trav_below [0:MAX_COUNT];
    logic [MAX_COUNT:0]        occ;
    logic signed [DATA_W-1:0]  cell_value [0:MAX_COUNT];
    logic [RANK_W-1:0]         cell_rank  [0:MAX_COUNT];

    assign o_busy   = (r_state != ST_LOAD);
    assign accept   = i_start && !o_busy;
    assign store    = accept && (r_count < MAX_C);
    assign shift    = (r_state == ST_EMIT);
    assign any_trav = |trav_vld[MAX_COUNT:1];

    assign trav_vld[0]   = store;
    assign trav_value[0] = i_value;
    assign trav_below[0] = '0;

    assign occ[MAX_COUNT]        = 1'b0;
    assign cell_value[MAX_COUNT] = '0;
    assign cell_rank[MAX_COUNT]  = '0;

    for (genvar g = 0; g < MAX_COUNT; g++) begin : g_cell
        rt_cell #(
            .RANK_W (RANK_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_shift      (shift),
            .i_trav_vld   (trav_vld[g]),
            .i_trav_value (trav_value[g]),
            .i_trav_below (trav_below[g]),
            .o_trav_vld   (trav_vld[g+1]),
            .o_trav_value (trav_value[g+1]),
            .o_trav_below (trav_below[g+1]),
            .i_nxt_occ    (occ[g+1]),
            .i_nxt_value  (cell_value[g+1]),
            .i_nxt_rank   (cell_rank[g+1]),
            .o_occ        (occ[g]),
            .o_value      (cell_value[g]),
            .o_rank       (cell_rank[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_left  <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_left  <= n_left;
            r_ovf   <= n_ovf;
        end
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_left  = r_left;
        n_ovf   = r_ovf;
        case (r_state)
            ST_LOAD: begin
                if (accept) begin
                    if (store) begin
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (!any_trav) begin
                    n_state = ST_EMIT;
                    n_left  = r_count;
                end
            end
            ST_EMIT: begin
                n_left = r_left - CNT_W'(1);
                if (r_left == CNT_W'(1)) begin
                    n_state = ST_LOAD;
                    n_count = '0;
                    n_ovf   = 1'b0;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // A one-element list returns the element itself instead of its rank.
    assign o_valid     = shift;
    assign o_result    = (r_count == CNT_W'(1)) ? cell_value[0]
                                                : DATA_W'(cell_rank[0]);
    assign o_last_res  = shift && (r_left == CNT_W'(1));
    assign o_truncated = r_ovf;

`ifndef NO_ASSERTIONS
    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_count != '0) && occ[0])
        else $error("result emitted from an empty chain");

    a_emit_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !any_trav)
        else $error("result emitted while an item is still moving");

    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last) |=> o_busy)
        else $error("block not busy after the final item");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_res |=> !o_valid && !o_busy && (r_count == '0))
        else $error("run did not close after its final result");
`endif

endmodule : rank_transform_top

>>> rtl/rt_cell.sv
// ----------------------------------------------------------------------------
// rt_cell
// One slot of the rank chain. Holds a stored value and its rank, compares a
// passing item against it and stores it if the slot is free, else passes it on.
// ----------------------------------------------------------------------------
module rt_cell
    import rt_pkg::*;
#(
    parameter int RANK_W = 6
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_shift,
    // Item traveling down the chain
    input  logic                     i_trav_vld,
    input  logic signed [DATA_W-1:0] i_trav_value,
    input  logic [RANK_W-1:0]        i_trav_below,
    output logic                     o_trav_vld,
    output logic signed [DATA_W-1:0] o_trav_value,
    output logic [RANK_W-1:0]        o_trav_below,
    // Stored contents of the next cell, used while unloading
    input  logic                     i_nxt_occ,
    input  logic signed [DATA_W-1:0] i_nxt_value,
    input  logic [RANK_W-1:0]        i_nxt_rank,
    output logic                     o_occ,
    output logic signed [DATA_W-1:0] o_value,
    output logic [RANK_W-1:0]        o_rank
);

    logic                     r_occ;
    logic signed [DATA_W-1:0] r_value;
    logic [RANK_W-1:0]        r_rank;
    logic                     r_fwd_vld;
    logic signed [DATA_W-1:0] r_fwd_value;
    logic [RANK_W-1:0]        r_fwd_below;

    logic stored_lt;
    logic trav_lt;

    assign stored_lt = r_value < i_trav_value;
    assign trav_lt   = i_trav_value < r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ     <= 1'b0;
            r_fwd_vld <= 1'b0;
        end else if (i_shift) begin
            r_occ     <= i_nxt_occ;
            r_fwd_vld <= 1'b0;
        end else begin
            // An item that finds this slot taken moves on; otherwise it settles here.
            r_fwd_vld <= i_trav_vld && r_occ;
            if (i_trav_vld && !r_occ) begin
                r_occ <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_value <= i_nxt_value;
            r_rank  <= i_nxt_rank;
        end else if (i_trav_vld) begin
            if (!r_occ) begin
                r_value <= i_trav_value;
                r_rank  <= i_trav_below;
            end else if (trav_lt) begin
                r_rank <= r_rank + RANK_W'(1);
            end
        end
        r_fwd_value <= i_trav_value;
        r_fwd_below <= i_trav_below + RANK_W'(stored_lt && r_occ);
    end

    assign o_trav_vld   = r_fwd_vld;
    assign o_trav_value = r_fwd_value;
    assign o_trav_below = r_fwd_below;
    assign o_occ        = r_occ;
    assign o_value      = r_value;
    assign o_rank       = r_rank;

endmodule : rt_cell

>>> sim/rank_transform_top_tb.sv
// ----------------------------------------------------------------------------
// rank_transform_top_tb
// Self-checking bench for the rank transform block. A short table of lists
// (single elements, signed extremes, equal values, mixed signs) runs first,
// followed by random lists of many lengths, including full and overflowing
// ones. A behavioral predictor ranks each list as it closes, and every result
// pulse is compared in order against the expected ranks. Sender gaps vary by
// phase.
// ----------------------------------------------------------------------------
module rank_transform_top_tb
    import rt_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_COUNT    = DEF_MAX_COUNT;
    localparam int N_ITEMS      = 480;
    localparam int DRAIN_CYCLES = 2 * MAX_COUNT + 16;
    localparam int N_DIR        = 20;

    typedef logic signed [DATA_W-1:0] t_word;

    localparam t_word W_MIN = 32'sh8000_0000;
    localparam t_word W_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        t_word result;
        logic  last_res;
        logic  truncated;
    } t_rank_res;

    typedef struct packed {
        t_word value;
        logic  last;
        logic  typed;
        t_word rank;
    } t_dir_row;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_start;
    logic  o_busy;
    t_word i_value;
    logic  i_last;
    logic  o_valid;
    t_word o_result;
    logic  o_last_res;
    logic  o_truncated;

    rank_transform_top #(
        .MAX_COUNT(MAX_COUNT)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_value    (i_value),
        .i_last     (i_last),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .o_last_res (o_last_res),
        .o_truncated(o_truncated)
    );

    // Predictor state: the list being loaded and the ranks still to come.
    t_word     list_vals[$];
    logic      list_typed[$];
    t_word     list_rank[$];
    logic      list_dropped;
    t_rank_res rank_q[$];
    t_rank_res seen_exp;

    int err_count;
    int items_sent;
    int dropped_items;
    int lists_done;
    int trunc_runs;
    int results_seen;
    int idle_pct;

    // Directed lists. A typed rank overrides the predictor for that element.
    t_dir_row dir_rows [N_DIR] = '{
        '{W_MIN,         1'b1, 1'b1, W_MIN},
        '{W_MAX,         1'b1, 1'b1, W_MAX},
        '{32'sd0,        1'b1, 1'b1, 32'sd0},
        '{-32'sd1,       1'b1, 1'b1, -32'sd1},
        '{W_MAX,         1'b0, 1'b1, 32'sd1},
        '{W_MIN,         1'b1, 1'b1, 32'sd0},
        '{32'sd7,        1'b0, 1'b1, 32'sd0},
        '{32'sd7,        1'b0, 1'b1, 32'sd0},
        '{32'sd7,        1'b1, 1'b1, 32'sd0},
        '{32'sd3,        1'b0, 1'b0, 32'sd0},
        '{-32'sd5,       1'b0, 1'b0, 32'sd0},
        '{32'sd3,        1'b0, 1'b0, 32'sd0},
        '{32'sd0,        1'b0, 1'b0, 32'sd0},
        '{32'sd100,      1'b1, 1'b0, 32'sd0},
        '{-32'sd1,       1'b0, 1'b1, 32'sd0},
        '{32'sd0,        1'b1, 1'b1, 32'sd1},
        '{32'sd1,        1'b0, 1'b0, 32'sd0},
        '{W_MIN,         1'b0, 1'b0, 32'sd0},
        '{W_MAX,         1'b0, 1'b0, 32'sd0},
        '{-32'sd1,       1'b1, 1'b0, 32'sd0}
    };

    int phase_pct [4] = '{0, 59, 0, 17};

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Stores one element (or drops it when the list is full); on the last one, ranks the whole list.
    function automatic void take_element(input t_word value, input logic last,
                                         input logic typed, input t_word rank);
        t_rank_res r;
        int n;
        int below;
        if (list_vals.size() < MAX_COUNT) begin
            list_vals.push_back(value);
            list_typed.push_back(typed);
            list_rank.push_back(rank);
        end else begin
            list_dropped = 1'b1;
            dropped_items++;
        end
        if (last) begin
            n = list_vals.size();
            for (int i = 0; i < n; i++) begin
                below = 0;
                for (int j = 0; j < n; j++) begin
                    if (list_vals[j] < list_vals[i]) below++;
                end
                r.result    = (n == 1) ? list_vals[i] : t_word'(below);
                if (list_typed[i]) r.result = list_rank[i];
                r.last_res  = (i == n - 1);
                r.truncated = list_dropped;
                rank_q.push_back(r);
            end
            if (list_dropped) trunc_runs++;
            lists_done++;
            list_vals.delete();
            list_typed.delete();
            list_rank.delete();
            list_dropped = 1'b0;
        end
    endfunction

    function automatic int pick_gap();
        int g;
        g = 0;
        while (g < 24 && $urandom_range(99) < idle_pct) g++;
        return g;
    endfunction

    function automatic t_word pick_value(input int mode);
        t_word v;
        case (mode)
            0: v = t_word'($urandom);
            1: v = t_word'($urandom_range(15)) - 32'sd8;
            default: begin
                case ($urandom_range(6))
                    0: v = W_MIN;
                    1: v = W_MAX;
                    2: v = W_MIN + 32'sd1;
                    3: v = W_MAX - 32'sd1;
                    4: v = 32'sd0;
                    5: v = -32'sd1;
                    default: v = t_word'($urandom);
                endcase
            end
        endcase
        return v;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_element(input t_word value, input logic last,
                                input logic typed, input t_word rank);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_value <= value;
        i_last  <= last;
        do @(posedge i_clk); while (o_busy);
        take_element(value, last, typed, rank);
        @(negedge i_clk);
    endtask

    task automatic send_list(input int len, input int mode);
        for (int k = 0; k < len; k++) begin
            if (k < MAX_COUNT) items_sent++;
            idle_pct = phase_pct[(items_sent * 4 / N_ITEMS) % 4];
            send_element(pick_value(mode), k == len - 1, 1'b0, '0);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (rank_q.size() == 0) begin
                err_count++;
                $display("%0t: result %0d with none expected", $time, o_result);
            end else begin
                seen_exp = rank_q.pop_front();
                if (o_result !== seen_exp.result) begin
                    err_count++;
                    $display("%0t: result expected %0d got %0d",
                             $time, seen_exp.result, o_result);
                end
                if (o_last_res !== seen_exp.last_res) begin
                    err_count++;
                    $display("%0t: last_res expected %0b got %0b",
                             $time, seen_exp.last_res, o_last_res);
                end
                if (o_truncated !== seen_exp.truncated) begin
                    err_count++;
                    $display("%0t: truncated expected %0b got %0b",
                             $time, seen_exp.truncated, o_truncated);
                end
            end
        end
    end

    initial begin
        int len;
        int waited;
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_value      = '0;
        i_last       = 1'b0;
        list_dropped = 1'b0;
        err_count    = 0;
        items_sent   = 0;
        idle_pct     = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_DIR; r++) begin
            items_sent++;
            send_element(dir_rows[r].value, dir_rows[r].last,
                         dir_rows[r].typed, dir_rows[r].rank);
        end

        // A full list and an overflowing one first, then a length mix.
        send_list(MAX_COUNT, 0);
        send_list(MAX_COUNT + 3, 1);
        while (items_sent < N_ITEMS) begin
            case ($urandom_range(19))
                0:       len = $urandom_range(MAX_COUNT + 6, MAX_COUNT - 4);
                1, 2, 3: len = $urandom_range(40, 11);
                default: len = $urandom_range(10, 1);
            endcase
            send_list(len, $urandom_range(2));
        end
        i_start <= 1'b0;

        waited = 0;
        while (rank_q.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (rank_q.size() != 0) begin
            err_count++;
            $display("%0t: %0d expected results never arrived", $time, rank_q.size());
        end

        $display("Ran %0d lists (%0d elements stored), %0d results checked.",
                 lists_done, items_sent, results_seen);
        $display("%0d runs overflowed capacity, %0d elements dropped.",
                 trunc_runs, dropped_items);
        if (err_count == 0) begin
            $display("rank_transform_top: match");
        end else begin
            $display("rank_transform_top: mismatch");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Run timed out.");
        $display("rank_transform_top: mismatch");
        $finish;
    end

endmodule : rank_transform_top_tb

>>> rank_transform_top.f
rtl/rt_pkg.sv
rtl/rt_cell.sv
rtl/rank_transform_top.sv
sim/rank_transform_top_tb.sv
